// ----- rtl/core/kat_pkg.sv -----
// Shared types and constants for the keyed alarm table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kat_pkg;
  localparam int Capacity = 64;
  localparam int SlotW = 6;
  localparam int CountW = 7;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_READ = 3'd1,
    OP_FIND = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] ident;
    logic [7:0] st;
  } entry_t;

  typedef struct packed {
    logic load;
    logic [SlotW-1:0] load_slot;
    entry_t load_entry;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/kat_cell.sv -----
// One storage cell of the entry chain; rotates its entry to the next cell.
// Depends on kat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kat_cell (
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire logic               load,
  input  kat_pkg::entry_t         load_entry,
  input  kat_pkg::entry_t         prev_entry,
  output kat_pkg::entry_t         entry
);
  import kat_pkg::*;
  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= load_entry;
    end else if (shift) begin
      entry_r <= prev_entry;
    end
  end

  assign entry = entry_r;
endmodule
`default_nettype wire

// ----- rtl/core/kat_chain.sv -----
// Ring of cells holding the table. Cell 0 is the head, read by the controller.
// A rotation by one moves every entry one slot down; Capacity rotations restore order.
// Depends on kat_pkg, kat_cell.
`timescale 1ns / 1ps
`default_nettype none
module kat_chain (
  input  wire logic         clk,
  input  wire logic         shift,
  input  kat_pkg::cell_ctl_t ctl,
  output kat_pkg::entry_t   head
);
  import kat_pkg::*;
  entry_t cells [Capacity];

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    kat_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .load      (ctl.load && ctl.load_slot == SlotW'(g)),
      .load_entry(ctl.load_entry),
      .prev_entry(cells[(g + 1) % Capacity]),
      .entry     (cells[g])
    );
  end

  assign head = cells[0];
endmodule
`default_nettype wire

// ----- rtl/core/keyed_alarm_table.sv -----
// Keyed alarm table: unordered table of up to 64 entries (address, id, state).
// Input: in_* stream, one operation per transfer. Output: out_* stream, one
// result per operation.
// Storage is a ring of 64 cells. Each operation rotates the ring through all
// 64 positions, comparing the head entry against the key one slot per cycle,
// and capturing the head at the requested slot (a delete takes the last live
// one). Writes happen at the end, in absolute slot order, once the ring is back
// in place. One operation is in flight at a time: the rotation, the write-back
// and an idle state to take the next transfer.
// The next operation is accepted as soon as the result is registered, even if
// the receiver stalls; a held result blocks only the following completion.
// Reset clears the count and control; entry contents are undefined until written.
// Depends on kat_pkg, kat_chain, kat_cell.
`timescale 1ns / 1ps
`default_nettype none
module keyed_alarm_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output wire logic        in_tready,
  // [2:0] operation, [18:3] alarm_address, [34:19] alarm_id, [42:35] alarm_state,
  // [43] update_only, [44] force_write, [50:45] slot_index, zero fill to 56
  input  wire logic [55:0] in_tdata,
  output wire logic        out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [7:2] found_slot, [23:8] out_address, [39:24] out_id,
  // [47:40] out_state, [48] stored, [55:49] alarm_count
  output wire logic [55:0] out_tdata
);
  import kat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [15:0] key_r, id_r;
  logic [7:0] st_r;
  logic upd_r, force_r;
  logic [SlotW-1:0] slot_r;
  logic [SlotW:0] pos_r;
  logic hit_r;
  logic [SlotW-1:0] hit_slot_r;
  entry_t hit_e_r, rd_e_r;
  logic [CountW-1:0] count_r;
  logic out_valid_r;
  logic [55:0] out_data_r;

  entry_t head;
  cell_ctl_t ctl;
  logic shift;
  logic [SlotW-1:0] pos_idx;
  logic live;

  assign pos_idx = pos_r[SlotW-1:0];
  assign live = {1'b0, pos_idx} < count_r;
  assign shift = state_r == S_SCAN;

  kat_chain u_chain (
    .clk  (clk),
    .shift(shift),
    .ctl  (ctl),
    .head (head)
  );

  assign in_tready = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  // result decode
  logic [1:0] r_status;
  logic [SlotW-1:0] r_slot;
  entry_t r_e;
  logic r_stored;
  logic [CountW-1:0] r_count;
  logic slot_ok;

  assign slot_ok = {1'b0, slot_r} < count_r;

  always_comb begin
    r_status = ST_MISS;
    r_slot = '0;
    r_e = '0;
    r_stored = 1'b0;
    r_count = count_r;
    ctl = '0;
    ctl.load_entry = '{addr: key_r, ident: id_r, st: st_r};
    case (op_r)
      OP_ADD: begin
        if (hit_r) begin
          r_status = ST_OK;
          r_slot = hit_slot_r;
          if (hit_e_r.st != st_r || force_r) begin
            r_stored = 1'b1;
            ctl.load = 1'b1;
            ctl.load_slot = hit_slot_r;
          end
        end else if (upd_r) begin
          r_status = ST_MISS;
        end else if (count_r < CountW'(Capacity)) begin
          r_status = ST_OK;
          r_slot = count_r[SlotW-1:0];
          r_stored = 1'b1;
          r_count = count_r + 1'b1;
          ctl.load = 1'b1;
          ctl.load_slot = count_r[SlotW-1:0];
        end else begin
          r_status = ST_FULL;
        end
      end
      OP_READ: begin
        if (slot_ok) begin
          r_status = ST_OK;
          r_slot = slot_r;
          r_e = rd_e_r;
        end
      end
      OP_FIND: begin
        if (hit_r) begin
          r_status = ST_OK;
          r_slot = hit_slot_r;
        end
      end
      OP_DELETE: begin
        if (slot_ok) begin
          r_status = ST_OK;
          r_slot = slot_r;
          r_count = count_r - 1'b1;
          ctl.load = 1'b1;
          ctl.load_slot = slot_r;
          ctl.load_entry = rd_e_r;
        end
      end
      OP_CLEAR: begin
        r_status = ST_OK;
        r_count = '0;
      end
      default: ;
    endcase
    if (state_r != S_DONE || (out_valid_r && !out_tready)) begin
      ctl.load = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (pos_r == (SlotW+1)'(Capacity - 1)) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
      hit_r <= 1'b0;
      pos_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_tvalid) begin
        hit_r <= 1'b0;
        pos_r <= '0;
      end
      if (state_r == S_SCAN) begin
        pos_r <= pos_r + 1'b1;
        if (live && !hit_r && head.addr == key_r) begin
          hit_r <= 1'b1;
        end
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        count_r <= r_count;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      op_r <= in_tdata[2:0];
      key_r <= in_tdata[18:3];
      id_r <= in_tdata[34:19];
      st_r <= in_tdata[42:35];
      upd_r <= in_tdata[43];
      force_r <= in_tdata[44];
      slot_r <= in_tdata[50:45];
    end
    if (state_r == S_SCAN) begin
      if (live && !hit_r && head.addr == key_r) begin
        hit_slot_r <= pos_idx;
        hit_e_r <= head;
      end
      if (op_r == OP_READ && pos_idx == slot_r) begin
        rd_e_r <= head;
      end
      if (op_r == OP_DELETE && pos_idx == count_r[SlotW-1:0] - 1'b1) begin
        rd_e_r <= head;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {r_count, r_stored, r_e.st, r_e.ident, r_e.addr, r_slot, r_status};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CountW'(Capacity))
    else $error("count exceeds capacity");
  assert property (@(posedge clk) disable iff (!rst_n) ctl.load |-> state_r == S_DONE)
    else $error("cell write outside completion");
  assert property (@(posedge clk) disable iff (!rst_n)
      (in_tvalid && in_tready) |=> state_r == S_SCAN && pos_r == '0)
    else $error("scan did not start");
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_data_r))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for keyed_alarm_table: drives table operations on the
// in_ stream, predicts each result with a local copy of the table, checks out_.
// Depends on kat_pkg and the keyed_alarm_table RTL.
`timescale 1ns / 1ps
module testbench;
  import kat_pkg::*;

  // lowest bit last, matching the out_tdata layout
  typedef struct packed {
    logic [6:0]  alarm_count;
    logic        stored;
    logic [7:0]  out_state;
    logic [15:0] out_id;
    logic [15:0] out_address;
    logic [5:0]  found_slot;
    logic [1:0]  status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;

  keyed_alarm_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  entry_t table_copy [Capacity];
  int live_count;
  reply_t replies_due [$];
  int mismatches;
  int sent_items;
  int checked_replies;
  int adds_stored;
  int full_hits;
  int idle_pct;
  logic [15:0] recent_keys [$];

  function automatic int key_lookup(logic [15:0] key);
    for (int k = 0; k < live_count; k++) begin
      if (table_copy[k].addr == key) return k;
    end
    return -1;
  endfunction

  function automatic reply_t apply_op(logic [2:0] op, logic [15:0] key, logic [15:0] ident,
                                      logic [7:0] st, logic upd, logic frc, logic [5:0] slot);
    reply_t r;
    int hit;
    r = '0;
    r.status = ST_MISS;
    case (op)
      OP_ADD: begin
        hit = key_lookup(key);
        if (hit >= 0) begin
          if (table_copy[hit].st != st || frc) begin
            table_copy[hit] = '{addr: key, ident: ident, st: st};
            r.stored = 1'b1;
          end
          r.status = ST_OK;
          r.found_slot = hit[5:0];
        end else if (upd) begin
          r.status = ST_MISS;
        end else if (live_count < Capacity) begin
          table_copy[live_count] = '{addr: key, ident: ident, st: st};
          r.found_slot = live_count[5:0];
          live_count++;
          r.stored = 1'b1;
          r.status = ST_OK;
        end else begin
          r.status = ST_FULL;
          full_hits++;
        end
        if (r.stored) adds_stored++;
      end
      OP_READ: begin
        if (slot < live_count) begin
          r.out_address = table_copy[slot].addr;
          r.out_id = table_copy[slot].ident;
          r.out_state = table_copy[slot].st;
          r.found_slot = slot;
          r.status = ST_OK;
        end
      end
      OP_FIND: begin
        hit = key_lookup(key);
        if (hit >= 0) begin
          r.found_slot = hit[5:0];
          r.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (slot < live_count) begin
          if (slot + 1 != live_count) table_copy[slot] = table_copy[live_count - 1];
          live_count--;
          r.found_slot = slot;
          r.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        live_count = 0;
        r.status = ST_OK;
      end
      default: r.status = ST_MISS;
    endcase
    r.alarm_count = live_count[6:0];
    return r;
  endfunction

  // called and returns at a falling edge; tvalid drops only while idling
  task automatic send_op(logic [2:0] op, logic [15:0] key, logic [15:0] ident,
                         logic [7:0] st, logic upd, logic frc, logic [5:0] slot);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {5'd0, slot, frc, upd, st, ident, key, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replies_due.push_back(apply_op(op, key, ident, st, upd, frc, slot));
    if (recent_keys.size() > 80) void'(recent_keys.pop_front());
    recent_keys.push_back(key);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = replies_due.pop_front();
        checked_replies++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: st %0d/%0d slot %0d/%0d addr %h/%h id %h/%h",
                      " s %h/%h wr %0d/%0d n %0d/%0d"},
                     want.status, got.status, want.found_slot, got.found_slot,
                     want.out_address, got.out_address, want.out_id, got.out_id,
                     want.out_state, got.out_state, want.stored, got.stored,
                     want.alarm_count, got.alarm_count);
        end
      end
    end
  end

  task automatic test_directed;
    send_op(OP_READ, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);        // empty read, bad slot
    send_op(OP_DELETE, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd63);
    send_op(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 6'd0);  // update-only miss
    send_op(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 6'd63);
    send_op(OP_ADD, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 6'd0);
    send_op(OP_ADD, 16'hFFFF, 16'h1234, 8'hFF, 1'b0, 1'b0, 6'd0);  // same state, no write
    send_op(OP_ADD, 16'hFFFF, 16'h1234, 8'hFF, 1'b1, 1'b1, 6'd0);  // forced rewrite
    send_op(OP_ADD, 16'h0000, 16'hABCD, 8'h5A, 1'b1, 1'b0, 6'd0);  // state change
    send_op(OP_FIND, 16'h0000, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);
    send_op(OP_FIND, 16'h7777, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);
    send_op(OP_READ, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd1);
    send_op(3'd5, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);
    send_op(3'd6, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);
    send_op(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 6'd63);
    send_op(OP_DELETE, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);      // moves last down
    send_op(OP_DELETE, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);      // last slot
    send_op(OP_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 6'd63);
    drain();
  endtask

  task automatic test_full_table;
    for (int k = 0; k < Capacity; k++)
      send_op(OP_ADD, 16'(k * 997), 16'($urandom), 8'($urandom), 1'b0, 1'b0, 6'($urandom));
    send_op(OP_ADD, 16'hBEEF, 16'h1, 8'h1, 1'b0, 1'b0, 6'd0);      // full
    send_op(OP_ADD, 16'hBEEF, 16'h1, 8'h1, 1'b1, 1'b0, 6'd0);      // update-only wins
    send_op(OP_READ, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd63);
    send_op(OP_FIND, 16'(63 * 997), 16'h0, 8'h0, 1'b0, 1'b0, 6'd0);
    send_op(OP_DELETE, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, 6'd63);
    drain();
  endtask

  task automatic test_random(int items);
    logic [2:0] op;
    logic [15:0] key;
    int pick;
    for (int n = 0; n < items; n++) begin
      idle_pct = (n >= items / 3 && n < items / 2) ? 0 : 34;
      pick = $urandom_range(99);
      if (pick < 40) op = OP_ADD;
      else if (pick < 58) op = OP_READ;
      else if (pick < 74) op = OP_FIND;
      else if (pick < 92) op = OP_DELETE;
      else if (pick < 95) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      if (recent_keys.size() != 0 && $urandom_range(2) != 0)
        key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else
        key = 16'($urandom);
      send_op(op, key, 16'($urandom), 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)),
              1'($urandom_range(3) == 0), 1'($urandom),
              6'($urandom_range(1) ? $urandom_range(live_count + 1) : $urandom));
      if (n == items / 4) drain();
    end
    drain();
  endtask

  initial begin
    mismatches = 0; sent_items = 0; checked_replies = 0;
    adds_stored = 0; full_hits = 0; idle_pct = 34; live_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_table();
    test_random(2000);
    $display("Covered %0d operations, %0d results checked, %0d entries written,",
             sent_items, checked_replies, adds_stored);
    $display("%0d full-table adds, with random and gap-free stalls on both sides.", full_hits);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("PASS keyed_alarm_table");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, replies_due.size());
      $display("FAIL keyed_alarm_table");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAIL keyed_alarm_table");
    $finish;
  end
endmodule
